// ===== design/push_to_talk_button_controller_assert.svh =====
// assertion macros for the push-to-talk button controller
// used by the port checker; no other dependencies
`ifndef PUSH_TO_TALK_BUTTON_CONTROLLER_ASSERT_SVH
`define PUSH_TO_TALK_BUTTON_CONTROLLER_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptt check failed");

// next-cycle implication, masked while reset is held
`define PTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptt check failed");

`endif

// ===== design/ptt_pkg.sv =====
// shared types, constants and the debounce step for the push-to-talk controller
// no dependencies
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] TOUCH_SETTLE_RST  = 4'd2;
  localparam logic [3:0] BUTTON_SETTLE_RST = 4'd5;
  localparam logic [7:0] HOLD_TICKS_RST    = 8'd13;
  localparam logic [7:0] PULSE_TICKS_RST   = 8'd2;

  // bit positions in the talk source mask
  localparam int SRC_TOUCH = 0;
  localparam int SRC_PWR   = 1;

  typedef enum logic [1:0] {
    REG_TOUCH_SETTLE  = 2'd0,
    REG_BUTTON_SETTLE = 2'd1,
    REG_HOLD_TICKS    = 2'd2,
    REG_PULSE_TICKS   = 2'd3
  } ptt_reg_t;

  typedef struct packed {
    logic [7:0] pulse_ticks;
    logic [7:0] hold_ticks;
    logic [3:0] button_settle;
    logic [3:0] touch_settle;
  } ptt_cfg_t;

  // one scan tick; touch sits in bit 0, mute in bit 5
  typedef struct packed {
    logic muted;
    logic link;
    logic pwr_ok;
    logic pwr;
    logic boot;
    logic touch;
  } ptt_ev_t;

  typedef struct packed {
    logic       stable;
    logic       cand;
    logic [3:0] count;
  } ptt_db_t;

  function automatic ptt_db_t settle(input ptt_db_t d, input logic raw,
                                     input logic [3:0] need);
    ptt_db_t n;
    n = d;
    if (raw == d.stable) begin
      n.cand  = raw;
      n.count = '0;
    end else if (raw != d.cand) begin
      n.cand  = raw;
      n.count = 4'd1;
    end else begin
      if (d.count < need) n.count = d.count + 4'd1;
      if (n.count >= need) begin
        n.stable = raw;
        n.count  = '0;
      end
    end
    return n;
  endfunction

endpackage

// ===== design/ptt_front.sv =====
// front end: takes scan ticks and runs the touch, boot and pwr debouncers
// depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptt_pkg::ptt_ev_t  raw,
  input  ptt_pkg::ptt_cfg_t cfg,
  input  logic              q_full,
  output logic              push,
  output ptt_pkg::ptt_ev_t  ev
);

  ptt_pkg::ptt_db_t touch_db_r, boot_db_r, pwr_db_r;
  ptt_pkg::ptt_db_t touch_db_nxt, boot_db_nxt, pwr_db_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    touch_db_nxt = ptt_pkg::settle(touch_db_r, raw.touch, cfg.touch_settle);
    boot_db_nxt  = ptt_pkg::settle(boot_db_r, raw.boot, cfg.button_settle);
    // pwr debouncer frozen on ticks with a bad pwr read
    pwr_db_nxt   = raw.pwr_ok ? ptt_pkg::settle(pwr_db_r, raw.pwr, cfg.button_settle)
                              : pwr_db_r;
    ev        = raw;
    ev.touch  = touch_db_nxt.stable;
    ev.boot   = boot_db_nxt.stable;
    ev.pwr    = pwr_db_nxt.stable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_db_r <= '0;
      boot_db_r  <= '0;
      pwr_db_r   <= '0;
    end else if (push) begin
      touch_db_r <= touch_db_nxt;
      boot_db_r  <= boot_db_nxt;
      pwr_db_r   <= pwr_db_nxt;
    end
  end

endmodule

// ===== design/ptt_queue.sv =====
// short register queue between the debounce front end and the control back end
// depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_queue #(
  parameter int DEPTH = ptt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ptt_pkg::ptt_ev_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output ptt_pkg::ptt_ev_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptt_pkg::ptt_ev_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== design/ptt_back.sv =====
// back end: talk sources, tap pulse, clipboard and pwr arming, plus the result register
// depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ptt_pkg::ptt_cfg_t cfg,
  input  logic              q_valid,
  input  ptt_pkg::ptt_ev_t  ev,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data
);

  logic [1:0] src_r, src_nxt;
  logic       clip_r, clip_nxt;
  logic       ret_r, ret_nxt;
  logic [7:0] pc_r, pc_nxt;
  logic       wd_r, wd_nxt;
  logic       he_r, he_nxt;
  logic [7:0] hc_r, hc_nxt;
  logic       arm_r, arm_nxt;
  logic       lp_r, lp_nxt;
  logic       out_valid_r;
  logic [7:0] out_data_r, out_data_nxt;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    src_nxt  = src_r;
    clip_nxt = clip_r;
    ret_nxt  = ret_r;
    pc_nxt   = pc_r;
    wd_nxt   = wd_r;
    he_nxt   = he_r;
    hc_nxt   = hc_r;
    arm_nxt  = arm_r;

    // link drop releases the talk sources, the clipboard key and the return pulse
    if (lp_r && !ev.link) begin
      src_nxt  = '0;
      clip_nxt = 1'b0;
      ret_nxt  = 1'b0;
      pc_nxt   = '0;
    end
    lp_nxt = ev.link;

    if (ret_nxt) begin
      if (pc_nxt <= 8'd1) begin
        pc_nxt  = '0;
        ret_nxt = 1'b0;
      end else begin
        pc_nxt = pc_nxt - 8'd1;
      end
    end

    // touch: press, release (tap or end of hold), held count
    if (ev.touch && !wd_r) begin
      wd_nxt = 1'b1;
      he_nxt = 1'b0;
      hc_nxt = '0;
    end else if (!ev.touch && wd_r) begin
      wd_nxt = 1'b0;
      if (he_r) begin
        src_nxt[ptt_pkg::SRC_TOUCH] = 1'b0;
        he_nxt = 1'b0;
      end else if (src_nxt == '0 && ev.link) begin
        ret_nxt = 1'b1;
        pc_nxt  = (cfg.pulse_ticks == '0) ? 8'd1 : cfg.pulse_ticks;
      end
    end else if (ev.touch && hc_r != 8'hFF) begin
      hc_nxt = hc_r + 8'd1;
    end
    if (ev.touch && !he_nxt && hc_nxt >= cfg.hold_ticks) begin
      he_nxt = 1'b1;
      if (src_nxt != '0 || (ev.link && !ev.muted)) src_nxt[ptt_pkg::SRC_TOUCH] = 1'b1;
    end

    if (ev.link) clip_nxt = ev.boot;

    if (ev.pwr_ok) begin
      if (!ev.link) begin
        arm_nxt = 1'b0;
        src_nxt[ptt_pkg::SRC_PWR] = 1'b0;
      end else if (!ev.pwr) begin
        arm_nxt = 1'b1;
        src_nxt[ptt_pkg::SRC_PWR] = 1'b0;
      end else if (arm_r && !src_nxt[ptt_pkg::SRC_PWR]) begin
        // first source needs an unmuted mic
        if (src_nxt != '0 || !ev.muted) src_nxt[ptt_pkg::SRC_PWR] = 1'b1;
      end
    end

    out_data_nxt = {1'b0, arm_nxt, ev.touch, ret_nxt, clip_nxt,
                    src_nxt[ptt_pkg::SRC_PWR], src_nxt[ptt_pkg::SRC_TOUCH], |src_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= '0;
      clip_r      <= 1'b0;
      ret_r       <= 1'b0;
      pc_r        <= '0;
      wd_r        <= 1'b0;
      he_r        <= 1'b0;
      hc_r        <= '0;
      arm_r       <= 1'b0;
      lp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        src_r  <= src_nxt;
        clip_r <= clip_nxt;
        ret_r  <= ret_nxt;
        pc_r   <= pc_nxt;
        wd_r   <= wd_nxt;
        he_r   <= he_nxt;
        hc_r   <= hc_nxt;
        arm_r  <= arm_nxt;
        lp_r   <= lp_nxt;
      end
      if (pop)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/push_to_talk_button_controller.sv =====
// top level of the push-to-talk button controller: config registers and the three parts
// depends on ptt_pkg, ptt_front, ptt_queue and ptt_back
`timescale 1ns / 1ps
//
// usage
//   in_*  : one request per scan tick with the raw touch, boot and pwr samples,
//           the pwr read flag and the host link and mute levels
//   out_* : one request per scan tick with the talk, key and debug levels after it
//   cfg_* : apb register port, settle counts at 0x0 / 0x4, hold ticks 0x8,
//           pulse ticks 0xc; write only while no tick is in flight
// timing
//   a tick is debounced at the edge it is taken and parked in a short queue;
//   the control back end moves it into the result register at an edge where
//   that register is empty or being taken, and out_tvalid then shows it;
//   one tick per cycle while the result side drains, nothing iterates
// reset
//   rst_n low clears every debouncer, source, pulse and the queue; registers
//   return to 2, 5, 13, 2
// stalls
//   a stalled result holds in the result register while the queue keeps taking
//   ticks; in_tready drops only once the queue is full
//

module push_to_talk_button_controller #(
  parameter int QUEUE_DEPTH = ptt_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input tick
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] touch_raw [1] boot_raw [2] pwr_raw [3] pwr_read_ok [4] link_up [5] mic_muted
  input  logic [7:0]  in_tdata,
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] talk_active [1] touch_source [2] pwr_source [3] clipboard_key
  // [4] return_key [5] touch_level [6] pwr_armed_flag [7] zero
  output logic [7:0]  out_tdata,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ptt_pkg::ptt_cfg_t cfg_r;
  ptt_pkg::ptt_reg_t reg_sel;
  logic              cfg_wr;

  ptt_pkg::ptt_ev_t  raw_ev, front_ev, back_ev;
  logic              push, pop, q_full, q_valid;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = ptt_pkg::ptt_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_settle  <= ptt_pkg::TOUCH_SETTLE_RST;
      cfg_r.button_settle <= ptt_pkg::BUTTON_SETTLE_RST;
      cfg_r.hold_ticks    <= ptt_pkg::HOLD_TICKS_RST;
      cfg_r.pulse_ticks   <= ptt_pkg::PULSE_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ptt_pkg::REG_TOUCH_SETTLE:  cfg_r.touch_settle  <= cfg_pwdata[3:0];
        ptt_pkg::REG_BUTTON_SETTLE: cfg_r.button_settle <= cfg_pwdata[3:0];
        ptt_pkg::REG_HOLD_TICKS:    cfg_r.hold_ticks    <= cfg_pwdata[7:0];
        ptt_pkg::REG_PULSE_TICKS:   cfg_r.pulse_ticks   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ptt_pkg::REG_TOUCH_SETTLE:  cfg_prdata = {28'd0, cfg_r.touch_settle};
      ptt_pkg::REG_BUTTON_SETTLE: cfg_prdata = {28'd0, cfg_r.button_settle};
      ptt_pkg::REG_HOLD_TICKS:    cfg_prdata = {24'd0, cfg_r.hold_ticks};
      ptt_pkg::REG_PULSE_TICKS:   cfg_prdata = {24'd0, cfg_r.pulse_ticks};
      default:                    cfg_prdata = '0;
    endcase
  end

  // upper two tdata bits are padding
  assign raw_ev = ptt_pkg::ptt_ev_t'(in_tdata[5:0]);

  // debouncers, updated as each tick is taken
  ptt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .raw      (raw_ev),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .ev       (front_ev)
  );

  // decouples the debounce side from a stalled result
  ptt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (front_ev),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (back_ev)
  );

  // source, pulse and clipboard control with the result register
  ptt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .ev        (back_ev),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== design/ptt_checker.sv =====
// port-level checks for the push-to-talk controller, bound onto the top level
// depends on push_to_talk_button_controller_assert.svh
`timescale 1ns / 1ps
`include "push_to_talk_button_controller_assert.svh"

module ptt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result stays put
  `PTT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // talk flag is the or of the two sources
  `PTT_ASSERT_IMP(a_talk_or, clk, rst_n, out_tvalid, out_tdata[0] == (out_tdata[1] || out_tdata[2]))

  // a draining receiver keeps the input side open
  `PTT_ASSERT_IMP(a_drain_ready, clk, rst_n, $past(out_tready), in_tready)

  // padding bit of the result stays clear
  `PTT_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, !out_tdata[7])

endmodule

bind push_to_talk_button_controller ptt_checker u_ptt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/push_to_talk_button_controller_checker.sv =====
// checker for the push-to-talk button controller: watches the tick, result and register ports,
// predicts each result from its own copy of the controller state and compares field by field
// depends on ptt_pkg
`timescale 1ns / 1ps

module push_to_talk_button_controller_checker
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [0] touch_raw [1] boot_raw [2] pwr_raw [3] pwr_read_ok [4] link_up [5] mic_muted
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [0] talk_active [1] touch_source [2] pwr_source [3] clipboard_key
  // [4] return_key [5] touch_level [6] pwr_armed_flag [7] zero
  input  logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic spare;
    logic armed;
    logic touch_level;
    logic return_key;
    logic clipboard;
    logic pwr_source;
    logic touch_source;
    logic talk;
  } ptt_levels_t;

  localparam string LEVEL_NAME [8] = '{"talk_active", "touch_source", "pwr_source",
                                        "clipboard_key", "return_key", "touch_level",
                                        "pwr_armed_flag", "spare"};

  ptt_cfg_t    cfg;
  ptt_db_t     touch_db, boot_db, pwr_db;
  logic        touch_was_down, hold_engaged, armed, clip_held, return_held, link_prev;
  logic [7:0]  hold_count, pulse_left;
  logic [1:0]  talk_src;
  ptt_levels_t expected_levels [$];

  function automatic ptt_db_t debounce(input ptt_db_t d, input logic raw,
                                       input logic [3:0] need);
    ptt_db_t n;
    n = d;
    if (raw == d.stable) begin
      n.cand  = raw;
      n.count = '0;
    end else if (raw != d.cand) begin
      n.cand  = raw;
      n.count = 4'd1;
    end else begin
      if (n.count < need) n.count = n.count + 4'd1;
      if (n.count >= need) begin
        n.stable = raw;
        n.count  = '0;
      end
    end
    return n;
  endfunction

  // the first source to go on needs the link up and the mic unmuted
  function automatic void set_source(input int pos, input logic on, input logic link,
                                     input logic muted);
    logic [1:0] nxt;
    nxt = talk_src;
    nxt[pos] = on;
    if (nxt == talk_src) return;
    if (talk_src == 2'b00 && (!link || muted)) return;
    talk_src = nxt;
  endfunction

  function automatic ptt_levels_t scan_tick(input ptt_ev_t ev);
    ptt_levels_t r;
    logic        touch, pwr_on;
    if (link_prev && !ev.link) begin
      talk_src    = '0;
      clip_held   = 1'b0;
      return_held = 1'b0;
      pulse_left  = '0;
    end
    link_prev = ev.link;
    if (return_held) begin
      if (pulse_left <= 8'd1) begin
        pulse_left  = '0;
        return_held = 1'b0;
      end else begin
        pulse_left = pulse_left - 8'd1;
      end
    end
    touch_db = debounce(touch_db, ev.touch, cfg.touch_settle);
    touch = touch_db.stable;
    if (touch && !touch_was_down) begin
      touch_was_down = 1'b1;
      hold_engaged   = 1'b0;
      hold_count     = '0;
    end else if (!touch && touch_was_down) begin
      touch_was_down = 1'b0;
      if (hold_engaged) begin
        set_source(SRC_TOUCH, 1'b0, ev.link, ev.muted);
        hold_engaged = 1'b0;
      end else if (talk_src == 2'b00 && ev.link) begin
        return_held = 1'b1;
        pulse_left  = (cfg.pulse_ticks != 8'd0) ? cfg.pulse_ticks : 8'd1;
      end
    end else if (touch && hold_count != 8'hff) begin
      hold_count = hold_count + 8'd1;
    end
    if (touch && !hold_engaged && hold_count >= cfg.hold_ticks) begin
      hold_engaged = 1'b1;
      set_source(SRC_TOUCH, 1'b1, ev.link, ev.muted);
    end
    boot_db = debounce(boot_db, ev.boot, cfg.button_settle);
    if (boot_db.stable != clip_held && ev.link) clip_held = boot_db.stable;
    if (ev.pwr_ok) begin
      pwr_db = debounce(pwr_db, ev.pwr, cfg.button_settle);
      pwr_on = talk_src[SRC_PWR];
      if (!ev.link) begin
        armed = 1'b0;
        if (pwr_on) set_source(SRC_PWR, 1'b0, ev.link, ev.muted);
      end else if (!pwr_db.stable) begin
        armed = 1'b1;
        if (pwr_on) set_source(SRC_PWR, 1'b0, ev.link, ev.muted);
      end else if (armed && !pwr_on) begin
        set_source(SRC_PWR, 1'b1, ev.link, ev.muted);
      end
    end
    r.spare        = 1'b0;
    r.armed        = armed;
    r.touch_level  = touch_db.stable;
    r.return_key   = return_held;
    r.clipboard    = clip_held;
    r.pwr_source   = talk_src[SRC_PWR];
    r.touch_source = talk_src[SRC_TOUCH];
    r.talk         = (talk_src != 2'b00);
    return r;
  endfunction

  always @(posedge clk) begin
    ptt_levels_t want, got;
    if (!rst_n) begin
      cfg.touch_settle  = TOUCH_SETTLE_RST;
      cfg.button_settle = BUTTON_SETTLE_RST;
      cfg.hold_ticks    = HOLD_TICKS_RST;
      cfg.pulse_ticks   = PULSE_TICKS_RST;
      touch_db       = '0;
      boot_db        = '0;
      pwr_db         = '0;
      touch_was_down = 1'b0;
      hold_engaged   = 1'b0;
      hold_count     = '0;
      armed          = 1'b0;
      talk_src       = '0;
      clip_held      = 1'b0;
      return_held    = 1'b0;
      pulse_left     = '0;
      link_prev      = 1'b0;
      fail_count     = 0;
      expected_levels.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (ptt_reg_t'(cfg_paddr[3:2]))
          REG_TOUCH_SETTLE:  cfg.touch_settle  = cfg_pwdata[3:0];
          REG_BUTTON_SETTLE: cfg.button_settle = cfg_pwdata[3:0];
          REG_HOLD_TICKS:    cfg.hold_ticks    = cfg_pwdata[7:0];
          REG_PULSE_TICKS:   cfg.pulse_ticks   = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      // results first, so a result is never matched to a request taken at the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_levels.size() == 0) begin
          fail_count++;
          $display("%0t: result %b with nothing expected", $time, got);
        end else begin
          want = expected_levels.pop_front();
          for (int b = 0; b < 8; b++) begin
            if (want[b] !== got[b]) begin
              fail_count++;
              $display("%0t: %s expected %b actual %b", $time, LEVEL_NAME[b], want[b], got[b]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) expected_levels.push_back(scan_tick(in_tdata[5:0]));
    end
    pending = expected_levels.size();
  end

endmodule

// ===== test/push_to_talk_button_controller_tb.sv =====
// top of the push-to-talk button controller testbench: clock, reset, tick requests,
// register writes, result back-pressure and the verdict
// depends on ptt_pkg, push_to_talk_button_controller and push_to_talk_button_controller_checker
`timescale 1ns / 1ps

module push_to_talk_button_controller_tb;
  import ptt_pkg::*;

  // bit positions of the fields in one tick request
  localparam int FLD_TOUCH   = 0;
  localparam int FLD_BOOT    = 1;
  localparam int FLD_PWR     = 2;
  localparam int FLD_PWR_OK  = 3;
  localparam int FLD_LINK    = 4;
  localparam int FLD_MUTED   = 5;

  // watchdog limit, set with ample room above the slowest legal run
  localparam int CYCLE_LIMIT = 300000;

  // zero settle, zero hold, zero pulse: all-ones, press with immediate hold, release,
  // pwr arming into a source, link drop, and a hold refused while muted
  localparam logic [5:0] DIRECTED_A [13] = '{6'h00, 6'h3f, 6'h18, 6'h19, 6'h19, 6'h1c, 6'h1c,
                                             6'h08, 6'h38, 6'h39, 6'h39, 6'h38, 6'h38};
  // settle of one, longest hold and pulse: tap, tap during the pulse, pwr source,
  // tap refused while a source is held, pwr sample skipped
  localparam logic [5:0] DIRECTED_B [15] = '{6'h18, 6'h19, 6'h19, 6'h18, 6'h18, 6'h19, 6'h19,
                                             6'h18, 6'h18, 6'h1c, 6'h1c, 6'h1d, 6'h1d, 6'h1c,
                                             6'h14};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [0] touch_raw [1] boot_raw [2] pwr_raw [3] pwr_read_ok [4] link_up [5] mic_muted
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [0] talk_active [1] touch_source [2] pwr_source [3] clipboard_key
  // [4] return_key [5] touch_level [6] pwr_armed_flag [7] zero
  logic [7:0]  out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int cycle_count;
  int ticks_sent;
  int results_seen;
  int settings_used;
  int rx_stall;

  // idle-free stretches on either side, redrawn every few dozen requests
  logic sender_quiet;
  logic receiver_quiet;

  // register values in force, used to size press and release episodes
  int cur_touch;
  int cur_button;
  int cur_hold;

  push_to_talk_button_controller u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  push_to_talk_button_controller_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: a random stall before each result, none in quiet stretches
  initial begin
    out_tready   = 1'b0;
    results_seen = 0;
    forever begin
      rx_stall = receiver_quiet ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (rx_stall > 0) begin
        out_tready = 1'b0;
        repeat (rx_stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
    end
  end

  // one tick request; tvalid stays high into the next request when there is no gap
  task automatic send_tick(input logic [5:0] fields);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, fields};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // stop sending and let every predicted result come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // setup then access phase; unused upper data bits carry junk the block must ignore
  task automatic cfg_write(input ptt_reg_t idx, input logic [7:0] value);
    logic [31:0] word;
    word = $urandom;
    if (idx == REG_TOUCH_SETTLE || idx == REG_BUTTON_SETTLE) word[3:0] = value[3:0];
    else word[7:0] = value;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = word;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // registers only change once the block has nothing in flight
  task automatic apply_settings(input int ts, input int bs, input int ht, input int pt);
    drain_results();
    cfg_write(REG_TOUCH_SETTLE, ts[7:0]);
    cfg_write(REG_BUTTON_SETTLE, bs[7:0]);
    cfg_write(REG_HOLD_TICKS, ht[7:0]);
    cfg_write(REG_PULSE_TICKS, pt[7:0]);
    cur_touch  = ts;
    cur_button = bs;
    cur_hold   = ht;
    settings_used++;
  endtask

  // how long a level holds before it flips; touch presses are either taps or full holds
  function automatic int episode_len(input int fld, input logic level);
    case (fld)
      FLD_TOUCH: begin
        if (!level) return $urandom_range(1, cur_touch + 10);
        if ($urandom_range(0, 1) == 0) return $urandom_range(1, cur_touch + 3);
        return cur_hold + cur_touch + $urandom_range(0, 12);
      end
      FLD_BOOT, FLD_PWR: return $urandom_range(1, 3 * cur_button + 6);
      FLD_LINK:  return level ? $urandom_range(30, 300) : $urandom_range(1, 15);
      FLD_MUTED: return level ? $urandom_range(1, 25) : $urandom_range(30, 250);
      default:   return 1;
    endcase
  endfunction

  // level episodes with random lengths, pwr reads that sometimes fail, and one-tick glitches
  task automatic random_ticks(input int n);
    logic [5:0] lvl;
    logic [5:0] fields;
    int         left [6];
    int         k;
    lvl = '0;
    lvl[FLD_LINK] = 1'b1;
    for (k = 0; k < 6; k++) left[k] = episode_len(k, lvl[k]);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        sender_quiet   = ($urandom_range(0, 3) == 0);
        receiver_quiet = ($urandom_range(0, 3) == 0);
      end
      // sender holds off mid phase until the block has caught up
      if (i == n / 2) drain_results();
      for (k = 0; k < 6; k++) begin
        if (k != FLD_PWR_OK) begin
          if (left[k] == 0) begin
            lvl[k]  = ~lvl[k];
            left[k] = episode_len(k, lvl[k]);
          end
          left[k]--;
        end
      end
      fields = lvl;
      fields[FLD_PWR_OK] = ($urandom_range(0, 11) != 0);
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(FLD_TOUCH, FLD_PWR);
        fields[k] = ~fields[k];
      end
      send_tick(fields);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    ticks_sent     = 0;
    settings_used  = 0;
    cur_touch      = TOUCH_SETTLE_RST;
    cur_button     = BUTTON_SETTLE_RST;
    cur_hold       = HOLD_TICKS_RST;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed cases at the register extremes
    apply_settings(0, 0, 0, 0);
    foreach (DIRECTED_A[i]) send_tick(DIRECTED_A[i]);
    apply_settings(1, 1, 255, 255);
    foreach (DIRECTED_B[i]) send_tick(DIRECTED_B[i]);

    // random phases, each under its own register setting
    apply_settings(TOUCH_SETTLE_RST, BUTTON_SETTLE_RST, HOLD_TICKS_RST, PULSE_TICKS_RST);
    random_ticks(250);
    apply_settings(1, 1, 1, 1);
    random_ticks(200);
    apply_settings(15, 15, 255, 255);
    random_ticks(330);
    apply_settings(0, 0, 0, 0);
    random_ticks(150);
    apply_settings(3, 7, 40, 20);
    random_ticks(200);
    apply_settings(15, 0, 6, 255);
    random_ticks(170);

    // final drain, then a short wait to catch any stray result
    drain_results();
    repeat (8) @(negedge clk);

    $display("%0d scan ticks sent, %0d results taken, %0d register settings",
             ticks_sent, results_seen, settings_used);
    $display("taps, holds, refused holds and taps, link drops and pwr arming, then level episodes");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
